// ===== rtl/patch_overlap_average_merge_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the patch overlap average merge block
// Shorthand for clocked implication checks with an asynchronous reset guard.
// ----------------------------------------------------------------------------
`ifndef PATCH_OVERLAP_AVERAGE_MERGE_ASSERT_SVH
`define PATCH_OVERLAP_AVERAGE_MERGE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define POAM_ASSERT_SAME(label, clock, resetn, ante, cons) \
    label: assert property (@(posedge clock) disable iff (!resetn) (ante) |-> (cons)) \
        else $error("poam assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define POAM_ASSERT_NEXT(label, clock, resetn, ante, cons) \
    label: assert property (@(posedge clock) disable iff (!resetn) (ante) |=> (cons)) \
        else $error("poam assertion failed");

`endif

// ===== rtl/poam_pkg.sv =====
// ----------------------------------------------------------------------------
// poam_pkg
// Shared widths, codes, the voxel word layout and the box clamp helper.
// ----------------------------------------------------------------------------
package poam_pkg;

    localparam int SUM_W     = 24;
    localparam int CNT_W     = 8;
    localparam int SAMPLE_W  = 16;
    localparam int BOX_W     = 11;
    localparam int POS_W     = 6;
    localparam int SIZE_W    = 7;
    localparam int COORD_W   = SIZE_W + 1;
    localparam int CFG_IDX_W = 2;

    localparam int DEF_DIM_X = 64;
    localparam int DEF_DIM_Y = 64;
    localparam int DEF_DIM_Z = 64;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd64;
    localparam logic [CNT_W-1:0]  CNT_MAX    = 8'd255;

    localparam logic OP_ACC  = 1'b0;
    localparam logic OP_READ = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Z = 2'd2;

    typedef struct packed {
        logic [CNT_W-1:0]        count;
        logic signed [SUM_W-1:0] sum;
    } voxel_t;

    localparam int VOXEL_W = $bits(voxel_t);

    // Clamp a signed box corner to the range [0, hi].
    function automatic logic [SIZE_W-1:0] clamp_axis(
        input logic signed [BOX_W-1:0] v,
        input logic [SIZE_W-1:0]       hi
    );
        logic signed [BOX_W-1:0] hi_s;
        hi_s = $signed(BOX_W'(hi));
        if (v < 0)
            return '0;
        else if (v > hi_s)
            return hi;
        else
            return v[SIZE_W-1:0];
    endfunction

endpackage

// ===== rtl/patch_overlap_average_merge.sv =====
// ----------------------------------------------------------------------------
// patch_overlap_average_merge
// Stitches 3-D patches into one volume by averaging overlapping samples.
// ----------------------------------------------------------------------------
// Input beats arrive on in_valid/in_ready. An accumulate beat (op = 0) maps a
// patch voxel through its clamped box and adds it to the voxel's sum and count;
// it yields no result. A readout beat (op = 1) returns sum / count and the count
// on out_valid/out_ready and clears that voxel.
// One beat is worked on at a time through a read-modify-write of the voxel store
// (one synchronous RAM, registered read). An accumulate passes through the read
// and modify steps and then returns to idle. A readout goes through the store
// access, the bit-serial divider and the output load before out_valid rises; an
// empty voxel or one outside the store skips the divider.
// The output register holds a finished result while the next beat is taken;
// a stalled receiver only holds the block once a second result is ready.
// After reset all DIM_X * DIM_Y * DIM_Z store entries (262144 by default) are
// cleared one entry per cycle; in_ready stays low during that pass.
// The size registers reset to 64 and may be written at any time via cfg_we.
// ----------------------------------------------------------------------------
`include "patch_overlap_average_merge_assert.svh"

module patch_overlap_average_merge #(
    parameter int DIM_X = poam_pkg::DEF_DIM_X,
    parameter int DIM_Y = poam_pkg::DEF_DIM_Y,
    parameter int DIM_Z = poam_pkg::DEF_DIM_Z
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [poam_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [poam_pkg::SIZE_W-1:0]           cfg_data,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic                                  op,
    input  logic signed [poam_pkg::BOX_W-1:0]     box_x_start,
    input  logic signed [poam_pkg::BOX_W-1:0]     box_y_start,
    input  logic signed [poam_pkg::BOX_W-1:0]     box_z_start,
    input  logic signed [poam_pkg::BOX_W-1:0]     box_x_end,
    input  logic signed [poam_pkg::BOX_W-1:0]     box_y_end,
    input  logic signed [poam_pkg::BOX_W-1:0]     box_z_end,
    input  logic [poam_pkg::POS_W-1:0]            pos_x,
    input  logic [poam_pkg::POS_W-1:0]            pos_y,
    input  logic [poam_pkg::POS_W-1:0]            pos_z,
    input  logic signed [poam_pkg::SAMPLE_W-1:0]  sample,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [poam_pkg::SAMPLE_W-1:0]  averaged,
    output logic [poam_pkg::CNT_W-1:0]            hits
);

    import poam_pkg::*;

    localparam int DEPTH = DIM_X * DIM_Y * DIM_Z;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_READ  = 3'd2;
    localparam logic [2:0] S_MOD   = 3'd3;
    localparam logic [2:0] S_DIV   = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;

    logic [2:0] state_reg, state_next;

    logic [SIZE_W-1:0] size_x_reg, size_y_reg, size_z_reg;

    logic [AW-1:0] clr_addr_reg, clr_addr_next;

    logic                       op_reg;
    logic                       hit_reg;
    logic [COORD_W-1:0]         cx_reg, cy_reg, cz_reg;
    logic signed [SAMPLE_W-1:0] sample_reg;

    logic signed [SAMPLE_W-1:0] res_avg_reg, res_avg_next;
    logic [CNT_W-1:0]           res_hits_reg, res_hits_next;

    logic                       out_valid_reg, out_valid_next;
    logic signed [SAMPLE_W-1:0] averaged_reg;
    logic [CNT_W-1:0]           hits_reg;

    logic [SIZE_W-1:0]  eff_x, eff_y, eff_z;
    logic [SIZE_W-1:0]  sx_c, sy_c, sz_c, ex_c, ey_c, ez_c;
    logic [COORD_W-1:0] ax, ay, az;
    logic               acc_hit, rd_hit;

    logic [AW-1:0]        vox_addr;
    logic                 ram_we;
    logic [AW-1:0]        ram_waddr;
    voxel_t               ram_wdata;
    logic [VOXEL_W-1:0]   ram_rdata;
    voxel_t               vox;

    logic                 div_start;
    logic                 div_done;
    logic [SAMPLE_W-1:0]  div_quotient;

    logic accept;
    logic out_load;

    assign accept   = in_valid && in_ready;
    assign in_ready = (state_reg == S_IDLE);
    assign out_load = (state_reg == S_OUT) && (!out_valid_reg || out_ready);

    // Size registers; a size above the store extent is taken as the extent.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_x_reg <= SIZE_RESET;
            size_y_reg <= SIZE_RESET;
            size_z_reg <= SIZE_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_SIZE_X: size_x_reg <= cfg_data;
                CFG_SIZE_Y: size_y_reg <= cfg_data;
                CFG_SIZE_Z: size_z_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign eff_x = (32'(size_x_reg) > DIM_X) ? SIZE_W'(DIM_X) : size_x_reg;
    assign eff_y = (32'(size_y_reg) > DIM_Y) ? SIZE_W'(DIM_Y) : size_y_reg;
    assign eff_z = (32'(size_z_reg) > DIM_Z) ? SIZE_W'(DIM_Z) : size_z_reg;

    assign sx_c = clamp_axis(box_x_start, eff_x);
    assign sy_c = clamp_axis(box_y_start, eff_y);
    assign sz_c = clamp_axis(box_z_start, eff_z);
    assign ex_c = clamp_axis(box_x_end, eff_x);
    assign ey_c = clamp_axis(box_y_end, eff_y);
    assign ez_c = clamp_axis(box_z_end, eff_z);

    assign ax = COORD_W'(sx_c) + COORD_W'(pos_x);
    assign ay = COORD_W'(sy_c) + COORD_W'(pos_y);
    assign az = COORD_W'(sz_c) + COORD_W'(pos_z);

    assign acc_hit = (ax < COORD_W'(ex_c)) && (ay < COORD_W'(ey_c)) && (az < COORD_W'(ez_c));
    assign rd_hit  = (32'(pos_x) < DIM_X) && (32'(pos_y) < DIM_Y) && (32'(pos_z) < DIM_Z);

    // Capture the beat: the voxel coordinate and whether it touches the store.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg     <= op;
            sample_reg <= sample;
            if (op == OP_ACC)
            begin
                hit_reg <= acc_hit;
                cx_reg  <= ax;
                cy_reg  <= ay;
                cz_reg  <= az;
            end
            else
            begin
                hit_reg <= rd_hit;
                cx_reg  <= COORD_W'(pos_x);
                cy_reg  <= COORD_W'(pos_y);
                cz_reg  <= COORD_W'(pos_z);
            end
        end
    end

    assign vox_addr = AW'(cx_reg) * AW'(DIM_Y * DIM_Z)
                    + AW'(cy_reg) * AW'(DIM_Z)
                    + AW'(cz_reg);

    assign vox = voxel_t'(ram_rdata);

    poam_ram #(
        .DEPTH (DEPTH),
        .WIDTH (VOXEL_W),
        .AW    (AW)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (VOXEL_W'(ram_wdata)),
        .raddr (vox_addr),
        .rdata (ram_rdata)
    );

    poam_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (vox.sum),
        .divisor  (vox.count),
        .done     (div_done),
        .quotient (div_quotient)
    );

    // Store write port: zeroing during the clearing pass, else the update.
    always_comb
    begin
        ram_we          = 1'b0;
        ram_waddr       = vox_addr;
        ram_wdata.count = vox.count + CNT_W'(1);
        ram_wdata.sum   = vox.sum + SUM_W'(sample_reg);
        if (state_reg == S_CLEAR)
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_addr_reg;
            ram_wdata = '0;
        end
        else if (state_reg == S_MOD && hit_reg)
        begin
            if (op_reg == OP_READ)
            begin
                ram_we    = 1'b1;
                ram_wdata = '0;
            end
            else
            begin
                // A saturated voxel ignores further samples.
                ram_we = (vox.count != CNT_MAX);
            end
        end
    end

    assign div_start = (state_reg == S_MOD) && (op_reg == OP_READ) && hit_reg
                    && (vox.count != '0);

    always_comb
    begin
        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        res_avg_next  = res_avg_reg;
        res_hits_next = res_hits_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                clr_addr_next = clr_addr_reg + AW'(1);
                if (clr_addr_reg == AW'(DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                state_next = S_MOD;
            end
            S_MOD:
            begin
                if (op_reg == OP_ACC)
                begin
                    state_next = S_IDLE;
                end
                else if (!hit_reg)
                begin
                    res_avg_next  = '0;
                    res_hits_next = '0;
                    state_next    = S_OUT;
                end
                else if (vox.count == '0)
                begin
                    res_avg_next  = vox.sum[SAMPLE_W-1:0];
                    res_hits_next = '0;
                    state_next    = S_OUT;
                end
                else
                begin
                    res_hits_next = vox.count;
                    state_next    = S_DIV;
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    res_avg_next = div_quotient;
                    state_next   = S_OUT;
                end
            end
            S_OUT:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_addr_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_avg_reg  <= res_avg_next;
        res_hits_reg <= res_hits_next;
        if (out_load)
        begin
            averaged_reg <= res_avg_reg;
            hits_reg     <= res_hits_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign averaged  = averaged_reg;
    assign hits      = hits_reg;

    // An accumulate beat never reaches the result path.
    `POAM_ASSERT_NEXT(a_acc_no_result, clk, rst_n, (state_reg == S_MOD) && (op_reg == OP_ACC), state_reg == S_IDLE)
    // The store is written only by the clearing pass or the update step.
    `POAM_ASSERT_SAME(a_write_phase, clk, rst_n, ram_we, (state_reg == S_CLEAR) || (state_reg == S_MOD))
    // The divider finishes only while the sequencer waits for it.
    `POAM_ASSERT_SAME(a_div_owner, clk, rst_n, div_done, state_reg == S_DIV)
    // An empty voxel always reads back as zero.
    `POAM_ASSERT_SAME(a_empty_zero, clk, rst_n, out_valid && (hits == '0), averaged == '0)

endmodule

// ===== rtl/poam_ram.sv =====
// ----------------------------------------------------------------------------
// poam_ram
// Simple dual-port voxel store: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module poam_ram #(
    parameter int DEPTH = 2,
    parameter int WIDTH = 1,
    parameter int AW    = 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/poam_div.sv =====
// ----------------------------------------------------------------------------
// poam_div
// Radix-2 restoring divider: signed sum by unsigned count, one bit per cycle.
// ----------------------------------------------------------------------------
module poam_div (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic signed [poam_pkg::SUM_W-1:0]  dividend,
    input  logic [poam_pkg::CNT_W-1:0]         divisor,
    output logic                               done,
    output logic [poam_pkg::SAMPLE_W-1:0]      quotient
);

    import poam_pkg::*;

    localparam int STEP_W = $clog2(SUM_W + 1);

    logic [STEP_W-1:0] step_reg;
    logic              done_reg;
    logic [SUM_W-1:0]  dvd_reg;
    logic [CNT_W-1:0]  rem_reg;
    logic [CNT_W-1:0]  den_reg;
    logic              neg_reg;

    logic [CNT_W:0]    rem_sh;
    logic              fits;
    logic [CNT_W:0]    rem_diff;
    logic [SAMPLE_W-1:0] quo_low;

    // The partial remainder stays below the divisor, so the shifted value fits.
    assign rem_sh   = {rem_reg, dvd_reg[SUM_W-1]};
    assign fits     = rem_sh >= {1'b0, den_reg};
    assign rem_diff = rem_sh - {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= (step_reg == STEP_W'(1));
            if (start)
            begin
                step_reg <= STEP_W'(SUM_W);
            end
            else if (step_reg != '0)
            begin
                step_reg <= step_reg - STEP_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg <= dividend[SUM_W-1];
            dvd_reg <= dividend[SUM_W-1] ? (SUM_W'(0) - dividend) : dividend;
            den_reg <= divisor;
            rem_reg <= '0;
        end
        else if (step_reg != '0)
        begin
            dvd_reg <= {dvd_reg[SUM_W-2:0], fits};
            rem_reg <= fits ? rem_diff[CNT_W-1:0] : rem_sh[CNT_W-1:0];
        end
    end

    assign quo_low  = dvd_reg[SAMPLE_W-1:0];
    assign quotient = neg_reg ? (SAMPLE_W'(0) - quo_low) : quo_low;
    assign done     = done_reg;

endmodule
